/* rtl/ifrr_pkg.sv */
// Shared constants and codes of the idle framed request receiver.
`default_nettype none

package ifrr_pkg;

  localparam int unsigned MaxFrameLen = 64;
  localparam int unsigned RingDepth   = 8;

  localparam logic [7:0] AckMark = 8'h03;

  typedef enum logic [1:0] {
    CMD_RX_BYTE = 2'd0,
    CMD_IDLE    = 2'd1,
    CMD_POP_REQ = 2'd2,
    CMD_POP_ACK = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_QUEUED    = 3'd0,
    ST_ACK       = 3'd1,
    ST_BAD_SUM   = 3'd2,
    ST_RING_FULL = 3'd3,
    ST_ACK_FULL  = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_NONE      = 3'd6
  } status_e;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_DATA   = 1'b1
  } kind_e;

endpackage

`default_nettype wire

/* rtl/idle_framed_request_receiver.sv */
// Idle framed request receiver: frame buffer, request ring and ack slot in memory.
//
// Input channel (in_valid_i/in_ready_o) carries cmd_i and rx_byte_i: a received byte,
// a line-idle event that closes the frame, or a pop of the request ring or ack slot.
// Output channel (out_valid_o/out_ready_i) carries one result item per register load:
// a status (kind 0) or a frame data byte (kind 1), with last_o on the final result.
// A received byte gives no result. An idle event puts its status in the output
// register in the cycle after acceptance; when the frame is stored it is then
// copied from the frame buffer memory into its ring or ack slot, one byte a cycle,
// and no item is accepted meanwhile.
// A pop streams the stored frame through the ring memory read port: each byte
// passes through the ring read data register into the output register, one byte a
// cycle while out_ready_i stays high; the block returns to accept items after the
// last byte has entered the output register.
// Empty pops give one "nothing queued" status in the cycle after acceptance.
// A stall of the receiver holds the output register and the one pending memory read;
// the next input item waits until the output register is free or being taken.
// Reset empties the frame, the ring and the ack slot; memory contents are left as
// they are and are only read where written.
`default_nettype none

module idle_framed_request_receiver
  import ifrr_pkg::*;
#(
  parameter int unsigned MAX_FRAME_LEN = MaxFrameLen,
  parameter int unsigned RING_DEPTH    = RingDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] cmd_i,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            kind_o,
  output logic [2:0]      status_o,
  output logic [7:0]      data_byte_o,
  output logic [5:0]      byte_index_o,
  output logic            last_o
);

  localparam int unsigned IDX_W  = $clog2(MAX_FRAME_LEN);
  localparam int unsigned LEN_W  = $clog2(MAX_FRAME_LEN + 1);
  localparam int unsigned PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int unsigned SLOT_W = $clog2(RING_DEPTH + 1);
  localparam int unsigned ADDR_W = SLOT_W + IDX_W;
  localparam int unsigned RING_WORDS = 2 ** ADDR_W;

  localparam logic [SLOT_W-1:0] ACK_SLOT = SLOT_W'(RING_DEPTH);
  localparam logic [LEN_W-1:0]  MAX_LEN  = LEN_W'(MAX_FRAME_LEN);
  localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(RING_DEPTH);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(RING_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_COPY = 3'b010,
    S_POP  = 3'b100
  } state_e;

  // Memories: frame buffer, and ring slots with the ack slot as one extra slot.
  logic [7:0] frame_mem [MAX_FRAME_LEN];
  logic [7:0] ring_mem  [RING_WORDS];
  logic [7:0] frame_rdata_q;
  logic [7:0] ring_rdata_q;

  logic       frame_we, frame_re, ring_we, ring_re;

  state_e             state_q, state_d;
  logic [LEN_W-1:0]   frame_len_q, frame_len_d;
  logic [7:0]         sum_q, sum_d;
  logic [7:0]         first_q, first_d;
  logic [PTR_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [LEN_W-1:0]   ring_len_q [RING_DEPTH];
  logic               ring_len_we;
  logic [LEN_W-1:0]   ack_len_q, ack_len_d;
  logic               ack_full_q, ack_full_d;

  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [LEN_W-1:0]   xfer_len_q, xfer_len_d;
  logic [LEN_W-1:0]   rd_idx_q, rd_idx_d;
  logic               rd_pend_q, rd_pend_d;
  logic [IDX_W-1:0]   pend_idx_q, pend_idx_d;
  logic               pend_last_q, pend_last_d;

  logic               out_valid_q, out_valid_d;
  kind_e              out_kind_q, out_kind_d;
  status_e            out_status_q, out_status_d;
  logic [7:0]         out_data_q, out_data_d;
  logic [IDX_W-1:0]   out_idx_q, out_idx_d;
  logic               out_last_q, out_last_d;

  cmd_e               cmd;
  status_e            close_st;
  logic               out_free;
  logic               accept;
  logic               issue;
  logic [LEN_W-1:0]   head_len;

  assign cmd      = cmd_e'(cmd_i);
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept   = in_valid_i && in_ready_o;
  assign head_len = ring_len_q[head_q];

  always_comb begin
    if (frame_len_q == '0) begin
      close_st = ST_EMPTY;
    end else if (sum_q != 8'h00) begin
      close_st = ST_BAD_SUM;
    end else if (first_q == AckMark) begin
      close_st = ack_full_q ? ST_ACK_FULL : ST_ACK;
    end else begin
      close_st = (cnt_q == FULL_CNT) ? ST_RING_FULL : ST_QUEUED;
    end
  end

  always_comb begin
    state_d     = state_q;
    frame_len_d = frame_len_q;
    sum_d       = sum_q;
    first_d     = first_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    ack_len_d   = ack_len_q;
    ack_full_d  = ack_full_q;
    slot_d      = slot_q;
    xfer_len_d  = xfer_len_q;
    rd_idx_d    = rd_idx_q;
    rd_pend_d   = rd_pend_q;
    pend_idx_d  = pend_idx_q;
    pend_last_d = pend_last_q;
    ring_len_we = 1'b0;
    frame_we    = 1'b0;
    frame_re    = 1'b0;
    ring_we     = 1'b0;
    ring_re     = 1'b0;
    issue       = 1'b0;

    out_valid_d  = out_valid_q && !out_ready_i;
    out_kind_d   = out_kind_q;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    out_idx_d    = out_idx_q;
    out_last_d   = out_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          // Every command but a received byte answers with a status unless it streams.
          out_kind_d   = KIND_STATUS;
          out_data_d   = 8'h00;
          out_idx_d    = '0;
          out_last_d   = 1'b1;
          out_status_d = ST_NONE;
          rd_idx_d     = '0;
          unique case (cmd)
            CMD_RX_BYTE: begin
              if (frame_len_q != MAX_LEN) begin
                frame_we    = 1'b1;
                frame_len_d = frame_len_q + LEN_W'(1);
                sum_d       = sum_q + rx_byte_i;
                if (frame_len_q == '0) begin
                  first_d = rx_byte_i;
                end
              end
            end
            CMD_IDLE: begin
              out_valid_d  = 1'b1;
              out_status_d = close_st;
              frame_len_d  = '0;
              sum_d        = 8'h00;
              xfer_len_d   = frame_len_q;
              if (close_st == ST_QUEUED) begin
                slot_d      = SLOT_W'(tail_q);
                ring_len_we = 1'b1;
                tail_d      = (tail_q == LAST_PTR) ? '0 : tail_q + PTR_W'(1);
                cnt_d       = cnt_q + CNT_W'(1);
                state_d     = S_COPY;
              end else if (close_st == ST_ACK) begin
                slot_d     = ACK_SLOT;
                ack_full_d = 1'b1;
                ack_len_d  = frame_len_q;
                state_d    = S_COPY;
              end
            end
            CMD_POP_REQ: begin
              if (cnt_q == '0) begin
                out_valid_d = 1'b1;
              end else begin
                head_d = (head_q == LAST_PTR) ? '0 : head_q + PTR_W'(1);
                cnt_d  = cnt_q - CNT_W'(1);
                if (head_len == '0) begin
                  out_valid_d = 1'b1;
                end else begin
                  slot_d     = SLOT_W'(head_q);
                  xfer_len_d = head_len;
                  state_d    = S_POP;
                end
              end
            end
            CMD_POP_ACK: begin
              if (!ack_full_q) begin
                out_valid_d = 1'b1;
              end else begin
                ack_full_d = 1'b0;
                ack_len_d  = '0;
                if (ack_len_q == '0) begin
                  out_valid_d = 1'b1;
                end else begin
                  slot_d     = ACK_SLOT;
                  xfer_len_d = ack_len_q;
                  state_d    = S_POP;
                end
              end
            end
            default: ;
          endcase
        end
      end

      S_COPY: begin
        // Read the frame buffer one byte ahead of the ring write.
        issue     = (rd_idx_q != xfer_len_q);
        frame_re  = issue;
        ring_we   = rd_pend_q;
        rd_pend_d = issue;
        if (issue) begin
          pend_idx_d = rd_idx_q[IDX_W-1:0];
          rd_idx_d   = rd_idx_q + LEN_W'(1);
        end
        if (!issue && !rd_pend_q) begin
          state_d = S_IDLE;
        end
      end

      S_POP: begin
        // Issue a read only when the read data register is free or drains this cycle.
        issue   = (rd_idx_q != xfer_len_q) && (!rd_pend_q || out_free);
        ring_re = issue;
        if (rd_pend_q && out_free) begin
          out_valid_d  = 1'b1;
          out_kind_d   = KIND_DATA;
          out_status_d = ST_QUEUED;
          out_data_d   = ring_rdata_q;
          out_idx_d    = pend_idx_q;
          out_last_d   = pend_last_q;
          rd_pend_d    = 1'b0;
        end
        if (issue) begin
          rd_pend_d   = 1'b1;
          pend_idx_d  = rd_idx_q[IDX_W-1:0];
          pend_last_d = (rd_idx_q + LEN_W'(1)) == xfer_len_q;
          rd_idx_d    = rd_idx_q + LEN_W'(1);
        end
        if ((rd_idx_q == xfer_len_q) && !rd_pend_q) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      frame_len_q <= '0;
      sum_q       <= 8'h00;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      ack_len_q   <= '0;
      ack_full_q  <= 1'b0;
      slot_q      <= '0;
      xfer_len_q  <= '0;
      rd_idx_q    <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      frame_len_q <= frame_len_d;
      sum_q       <= sum_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      ack_len_q   <= ack_len_d;
      ack_full_q  <= ack_full_d;
      slot_q      <= slot_d;
      xfer_len_q  <= xfer_len_d;
      rd_idx_q    <= rd_idx_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q      <= first_d;
    pend_idx_q   <= pend_idx_d;
    pend_last_q  <= pend_last_d;
    out_kind_q   <= out_kind_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
    out_idx_q    <= out_idx_d;
    out_last_q   <= out_last_d;
    if (ring_len_we) begin
      ring_len_q[tail_q] <= frame_len_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_we) begin
      frame_mem[frame_len_q[IDX_W-1:0]] <= rx_byte_i;
    end
    if (frame_re) begin
      frame_rdata_q <= frame_mem[rd_idx_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[{slot_q, pend_idx_q}] <= frame_rdata_q;
    end
    if (ring_re) begin
      ring_rdata_q <= ring_mem[{slot_q, rd_idx_q[IDX_W-1:0]}];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_kind_q;
  assign status_o     = out_status_q;
  assign data_byte_o  = out_data_q;
  assign byte_index_o = 6'(out_idx_q);
  assign last_o       = out_last_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL_CNT)
    else $error("ring count above depth");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_len_q <= MAX_LEN)
    else $error("frame length above maximum");

  a_pend_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP && rd_pend_q && !out_free) |=> (rd_pend_q && $stable(ring_rdata_q)))
    else $error("pending read data lost under stall");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i == CMD_POP_REQ && cnt_q == '0)
      |=> (out_valid_q && out_status_q == ST_NONE && out_last_q))
    else $error("pop of empty ring without nothing-queued status");

  a_copy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i == CMD_IDLE && (close_st == ST_QUEUED || close_st == ST_ACK))
      |=> (state_q == S_COPY && !in_ready_o))
    else $error("stored frame did not start its copy");

endmodule

`default_nettype wire

/* tb/idle_framed_request_receiver_test.sv */
// Self-checking testbench for the idle framed request receiver.
module idle_framed_request_receiver_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ifrr_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned RandomItems = 380;

  typedef struct packed {
    kind_e      kind;
    status_e    status;
    logic [7:0] data;
    logic [5:0] index;
    logic       last;
  } frame_result_t;

  // Mirrors the receiver state and queues the results each accepted item causes.
  class frame_scoreboard;
    logic [7:0]    frame_buf [MaxFrameLen];
    int unsigned   frame_len;
    logic [7:0]    frame_sum;
    logic [7:0]    ring_mem [RingDepth][MaxFrameLen];
    int unsigned   ring_len [RingDepth];
    int unsigned   ring_head;
    int unsigned   ring_tail;
    int unsigned   ring_count;
    logic [7:0]    ack_mem [MaxFrameLen];
    int unsigned   ack_len;
    bit            ack_held;
    frame_result_t expected_results [$];
    int unsigned   mismatches;
    int unsigned   results_checked;
    int unsigned   data_checked;
    int unsigned   status_count [7];

    function void push_status(status_e st);
      frame_result_t r;
      r.kind   = KIND_STATUS;
      r.status = st;
      r.data   = '0;
      r.index  = '0;
      r.last   = 1'b1;
      expected_results.push_back(r);
    endfunction

    function void push_stream(logic [7:0] src [MaxFrameLen], int unsigned n);
      frame_result_t r;
      if (n > MaxFrameLen) n = MaxFrameLen;
      if (n == 0) begin
        push_status(ST_NONE);
        return;
      end
      for (int unsigned i = 0; i < n; i++) begin
        r.kind   = KIND_DATA;
        r.status = ST_QUEUED;
        r.data   = src[i];
        r.index  = 6'(i);
        r.last   = (i + 1 == n);
        expected_results.push_back(r);
      end
    endfunction

    function void note_item(cmd_e cmd, logic [7:0] rx);
      case (cmd)
        CMD_RX_BYTE: begin
          // drop bytes past the buffer, they never enter the sum
          if (frame_len < MaxFrameLen) begin
            frame_buf[frame_len] = rx;
            frame_len++;
            frame_sum += rx;
          end
        end
        CMD_IDLE: begin
          if (frame_len == 0) begin
            push_status(ST_EMPTY);
          end else if (frame_sum != 8'h00) begin
            push_status(ST_BAD_SUM);
          end else if (frame_buf[0] == AckMark) begin
            if (ack_held) begin
              push_status(ST_ACK_FULL);
            end else begin
              ack_mem  = frame_buf;
              ack_len  = frame_len;
              ack_held = 1'b1;
              push_status(ST_ACK);
            end
          end else if (ring_count >= RingDepth) begin
            push_status(ST_RING_FULL);
          end else begin
            ring_mem[ring_tail] = frame_buf;
            ring_len[ring_tail] = frame_len;
            ring_tail = (ring_tail + 1) % RingDepth;
            ring_count++;
            push_status(ST_QUEUED);
          end
          frame_len = 0;
          frame_sum = 8'h00;
        end
        CMD_POP_REQ: begin
          if (ring_count == 0) begin
            push_status(ST_NONE);
          end else begin
            push_stream(ring_mem[ring_head], ring_len[ring_head]);
            ring_head = (ring_head + 1) % RingDepth;
            ring_count--;
          end
        end
        default: begin
          if (!ack_held) begin
            push_status(ST_NONE);
          end else begin
            push_stream(ack_mem, ack_len);
            ack_held = 1'b0;
            ack_len  = 0;
          end
        end
      endcase
    endfunction

    function void check_field(string field, logic [7:0] exp_v, logic [7:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_result(logic kind, logic [2:0] status, logic [7:0] data,
                               logic [5:0] index, logic last);
      frame_result_t exp_r;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: kind %0h status %0h data %0h index %0h last %0h",
                 $time, kind, status, data, index, last);
        mismatches++;
        return;
      end
      exp_r = expected_results.pop_front();
      check_field("kind", 8'(exp_r.kind), 8'(kind));
      check_field("status", 8'(exp_r.status), 8'(status));
      check_field("data_byte", exp_r.data, data);
      check_field("byte_index", 8'(exp_r.index), 8'(index));
      check_field("last", 8'(exp_r.last), 8'(last));
      results_checked++;
      if (exp_r.kind == KIND_DATA) data_checked++;
      else status_count[exp_r.status]++;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [1:0] cmd_q = CMD_RX_BYTE;
  logic [7:0] byte_q = 8'h00;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic       kind;
  logic [2:0] status;
  logic [7:0] data_byte;
  logic [5:0] byte_index;
  logic       last;

  frame_scoreboard board = new();

  bit          sender_gaps_on = 1'b1;
  bit          receiver_stalls_on = 1'b1;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;

  idle_framed_request_receiver u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .cmd_i        (cmd_q),
    .rx_byte_i    (byte_q),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .kind_o       (kind),
    .status_o     (status),
    .data_byte_o  (data_byte),
    .byte_index_o (byte_index),
    .last_o       (last)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, board.pending());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Result side: check each taken result, stall in random bursts.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_result(kind, status, data_byte, byte_index, last);
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (receiver_stalls_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(cmd_e cmd, logic [7:0] rx);
    if (sender_gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd_q    <= cmd;
    byte_q   <= rx;
    do @(posedge clk); while (!in_ready);
    board.note_item(cmd, rx);
    items_sent++;
  endtask

  task automatic send_frame_bytes(logic [7:0] frame_bytes [$]);
    foreach (frame_bytes[i]) send_item(CMD_RX_BYTE, frame_bytes[i]);
    send_item(CMD_IDLE, 8'($urandom));
  endtask

  // Build a frame of n bytes; a good one sums to zero over the stored bytes.
  task automatic send_frame(int unsigned n, bit ack, bit good);
    logic [7:0]  frame_bytes [$];
    logic [7:0]  sum;
    int unsigned kept;
    kept = (n < MaxFrameLen) ? n : MaxFrameLen;
    for (int unsigned i = 0; i < n; i++) frame_bytes.push_back(8'($urandom));
    if (ack) frame_bytes[0] = AckMark;
    else if (frame_bytes[0] == AckMark) frame_bytes[0] = 8'hA5;
    if (kept == 1) begin
      frame_bytes[0] = good ? 8'h00 : (ack ? AckMark : 8'($urandom_range(1, 255)));
    end else begin
      sum = 8'h00;
      for (int unsigned i = 0; i + 1 < kept; i++) sum += frame_bytes[i];
      frame_bytes[kept-1] = -sum;
      if (!good) frame_bytes[kept-1] += 8'($urandom_range(1, 255));
    end
    send_frame_bytes(frame_bytes);
  endtask

  // Hold the sender until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  initial begin : stimulus
    int unsigned episode;
    int unsigned start_items;
    int unsigned len;
    int unsigned r;
    bit          fill_mode;
    bit          ack;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pops, empty frame, byte extremes, ack slot, bad sum.
    send_item(CMD_POP_REQ, 8'h00);
    send_item(CMD_POP_ACK, 8'hFF);
    send_item(CMD_IDLE, 8'h55);
    send_frame_bytes('{8'h00});
    send_frame_bytes('{8'hFF, 8'h01});
    send_frame_bytes('{AckMark, 8'hFD});
    send_frame_bytes('{AckMark, 8'h01, 8'hFC});
    send_frame_bytes('{8'h05, 8'h07});
    send_item(CMD_POP_ACK, 8'hAA);
    send_item(CMD_POP_REQ, 8'h0F);
    send_item(CMD_POP_REQ, 8'hF0);
    send_item(CMD_POP_REQ, 8'h33);

    // Random: alternate phases that fill the ring with phases that drain it.
    start_items = items_sent;
    episode = 0;
    fill_mode = 1'b1;
    while (items_sent - start_items < RandomItems) begin
      if (episode % 10 == 9) begin
        drain_results();
        fill_mode = !fill_mode;
        sender_gaps_on = $urandom_range(0, 2) != 0;
        receiver_stalls_on = $urandom_range(0, 2) != 0;
      end
      if (items_sent - start_items > RandomItems * 4 / 5) begin
        sender_gaps_on = 1'b0;
        receiver_stalls_on = 1'b0;
      end
      if (episode == 3) begin
        send_frame(66, 1'b0, 1'b1);
      end else if (episode == 20) begin
        send_frame(70, 1'b1, 1'b1);
      end else begin
        r = $urandom_range(0, 99);
        if (r < (fill_mode ? 12 : 45)) begin
          send_item(($urandom_range(0, 2) == 0) ? CMD_POP_ACK : CMD_POP_REQ, 8'($urandom));
        end else begin
          r = $urandom_range(0, 99);
          ack = (r >= 55 && r < 70) || (r >= 70 && r < 82 && $urandom_range(0, 1) == 1);
          len = ($urandom_range(0, 39) == 0) ? $urandom_range(58, 70)
                                              : $urandom_range(ack ? 2 : 1, 6);
          if (r < 70) send_frame(len, ack, 1'b1);
          else if (r < 82) send_frame(len, ack, 1'b0);
          else if (r < 90) send_item(CMD_IDLE, 8'($urandom));
          else send_item(cmd_e'(2'($urandom_range(0, 3))), 8'($urandom));
        end
      end
      episode++;
    end

    drain_results();
    repeat (150) @(posedge clk);

    $display("Summary: %0d items sent, %0d results checked, %0d of them frame bytes",
             items_sent, board.results_checked, board.data_checked);
    $display("Statuses: queued %0d, ack %0d, bad sum %0d, ring full %0d, ack full %0d, %s",
             board.status_count[ST_QUEUED], board.status_count[ST_ACK],
             board.status_count[ST_BAD_SUM], board.status_count[ST_RING_FULL],
             board.status_count[ST_ACK_FULL],
             $sformatf("empty %0d, none %0d", board.status_count[ST_EMPTY],
                       board.status_count[ST_NONE]));
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* idle_framed_request_receiver.f */
rtl/ifrr_pkg.sv
rtl/idle_framed_request_receiver.sv
tb/idle_framed_request_receiver_test.sv
